// ===== rtl/vmc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vmc_pkg
// Types, codes and constants shared by the vending machine controller files.
// ----------------------------------------------------------------------------
package vmc_pkg;

  // default sizes for the stock store
  localparam int SLOTS_DEF      = 8;
  localparam int STOCK_BITS_DEF = 8;

  // field widths of the event and result items
  localparam int MODE_W   = 3;
  localparam int SLOT_W   = 3;
  localparam int COIN_W   = 2;
  localparam int QTY_W    = 8;
  localparam int STATUS_W = 4;
  localparam int BAL_W    = 9;

  // packed price table: one byte per slot
  localparam int PRICE_SLOTS = 8;
  localparam int PRICE_W     = 8;
  localparam int TABLE_W     = PRICE_SLOTS * PRICE_W;

  // coin values
  localparam int COIN_VAL_W = 5;
  localparam logic [COIN_VAL_W-1:0] PENNY   = 5'd1;
  localparam logic [COIN_VAL_W-1:0] NICKEL  = 5'd5;
  localparam logic [COIN_VAL_W-1:0] DIME    = 5'd10;
  localparam logic [COIN_VAL_W-1:0] QUARTER = 5'd25;

  localparam logic [COIN_W-1:0] COIN_PENNY  = 2'd0;
  localparam logic [COIN_W-1:0] COIN_NICKEL = 2'd1;
  localparam logic [COIN_W-1:0] COIN_DIME   = 2'd2;

  // event modes
  localparam logic [MODE_W-1:0] MODE_SELECT   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_COIN     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_DISPENSE = 3'd2;
  localparam logic [MODE_W-1:0] MODE_REFUND   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_LOAD     = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] STS_SELECTED       = 4'd0;
  localparam logic [STATUS_W-1:0] STS_UNAVAILABLE    = 4'd1;
  localparam logic [STATUS_W-1:0] STS_SELECT_FIRST   = 4'd2;
  localparam logic [STATUS_W-1:0] STS_NONE_SELECTED  = 4'd3;
  localparam logic [STATUS_W-1:0] STS_NOTHING_REFUND = 4'd4;
  localparam logic [STATUS_W-1:0] STS_COIN_TAKEN     = 4'd5;
  localparam logic [STATUS_W-1:0] STS_PAID           = 4'd6;
  localparam logic [STATUS_W-1:0] STS_ALREADY_SEL    = 4'd7;
  localparam logic [STATUS_W-1:0] STS_INSUFFICIENT   = 4'd8;
  localparam logic [STATUS_W-1:0] STS_REFUNDED       = 4'd9;
  localparam logic [STATUS_W-1:0] STS_COIN_REJECTED  = 4'd10;
  localparam logic [STATUS_W-1:0] STS_DISPENSED      = 4'd11;
  localparam logic [STATUS_W-1:0] STS_STOCK_LOADED   = 4'd12;

  // machine state; dispensing is momentary and never held
  typedef enum logic [1:0] {
    ST_IDLE     = 2'd0,
    ST_SELECTED = 2'd1,
    ST_PAID     = 2'd2
  } state_t;

  function automatic logic [COIN_VAL_W-1:0] coin_value(input logic [COIN_W-1:0] kind);
    logic [COIN_VAL_W-1:0] v;
    case (kind)
      COIN_PENNY:  v = PENNY;
      COIN_NICKEL: v = NICKEL;
      COIN_DIME:   v = DIME;
      default:     v = QUARTER;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/vmc_ifs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vmc_ifs
// Valid/ready channels for the event items and the result items.
// ----------------------------------------------------------------------------
interface vmc_event_if;
  logic                        valid;
  logic                        ready;
  logic [vmc_pkg::MODE_W-1:0]  mode;
  logic [vmc_pkg::SLOT_W-1:0]  slot;
  logic [vmc_pkg::COIN_W-1:0]  coin_kind;
  logic [vmc_pkg::QTY_W-1:0]   quantity;

  modport source (output valid, mode, slot, coin_kind, quantity, input ready);
  modport sink   (input valid, mode, slot, coin_kind, quantity, output ready);
endinterface

interface vmc_result_if;
  logic                          valid;
  logic                          ready;
  logic [vmc_pkg::STATUS_W-1:0]  status;
  logic                          dispensed;
  logic [vmc_pkg::SLOT_W-1:0]    dispensed_slot;
  logic [vmc_pkg::BAL_W-1:0]     returned_amount;
  logic                          coin_returned;
  logic [vmc_pkg::BAL_W-1:0]     balance_now;

  modport source (output valid, status, dispensed, dispensed_slot, returned_amount,
                  coin_returned, balance_now, input ready);
  modport sink   (input valid, status, dispensed, dispensed_slot, returned_amount,
                  coin_returned, balance_now, output ready);
endinterface
`default_nettype wire

// ===== rtl/vending_machine_controller.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vending_machine_controller
// Event-driven vending controller: select, coin, dispense, refund, stock load.
// ----------------------------------------------------------------------------
// usage
//   evt : event items in (mode, slot, coin_kind, quantity), valid/ready
//   res : one result item out per event, valid/ready
//   cfg_wr_en / cfg_wr_data : write of the packed price table, one byte per
//     slot; write it only while no event is in flight
// timing
//   an event is registered on accept into the input register and worked from
//   there when the output register is free or draining; its result is loaded
//   into the output register, which drives res.valid
//   one event per cycle sustained while res.ready is high; the loop that sets
//   this is the machine state, balance and stock update, one pass per event
// reset
//   rst (synchronous, active high) empties both stages, returns to idle with
//   zero balance, clears all stock counts and the price table
// stalls
//   a result held by res.ready low blocks the work stage; the input register
//   still takes one more event, then evt.ready drops until res drains
// ----------------------------------------------------------------------------
module vending_machine_controller #(
  parameter int SLOTS      = vmc_pkg::SLOTS_DEF,
  parameter int STOCK_BITS = vmc_pkg::STOCK_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_wr_en,
  input  wire logic [vmc_pkg::TABLE_W-1:0] cfg_wr_data,
  vmc_event_if.sink                        evt,
  vmc_result_if.source                     res
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // price table register
  logic [vmc_pkg::TABLE_W-1:0] price_table;

  // input register stage
  logic                       in_valid;
  logic [vmc_pkg::MODE_W-1:0] in_mode;
  logic [vmc_pkg::SLOT_W-1:0] in_slot;
  logic [vmc_pkg::COIN_W-1:0] in_coin;
  logic [vmc_pkg::QTY_W-1:0]  in_qty;

  // machine state
  vmc_pkg::state_t             state, state_next;
  logic [vmc_pkg::BAL_W-1:0]   balance, balance_next;
  logic [vmc_pkg::SLOT_W-1:0]  chosen_slot, chosen_next;
  // copy of the chosen slot's stock count, valid while a slot is selected
  logic [STOCK_BITS-1:0]       chosen_stock, chosen_stock_next;
  logic [STOCK_BITS-1:0]       stock [SLOTS];

  // output register stage
  logic                          out_valid;
  logic [vmc_pkg::STATUS_W-1:0]  out_status;
  logic                          out_disp;
  logic [vmc_pkg::SLOT_W-1:0]    out_slot;
  logic [vmc_pkg::BAL_W-1:0]     out_ret;
  logic                          out_coin_back;
  logic [vmc_pkg::BAL_W-1:0]     out_bal;

  // handshakes
  logic evt_fire;
  logic work_fire;

  assign work_fire = in_valid && (!out_valid || res.ready);
  assign evt.ready = !in_valid || work_fire;
  assign evt_fire  = evt.valid && evt.ready;

  // slot decode; slots beyond SLOTS do not exist
  logic [7:0]             slot_wide;
  logic [7:0]             chosen_wide;
  logic [IDX_W-1:0]       slot_idx;
  logic [IDX_W-1:0]       chosen_idx;
  logic                   slot_ok;
  logic [STOCK_BITS-1:0]  stock_sel;
  logic [23:0]            qty_wide;
  logic [STOCK_BITS-1:0]  qty_m;

  assign slot_wide   = {5'b0, in_slot};
  assign chosen_wide = {5'b0, chosen_slot};
  assign slot_idx    = slot_wide[IDX_W-1:0];
  assign chosen_idx  = chosen_wide[IDX_W-1:0];
  assign slot_ok     = slot_wide < 8'(SLOTS);
  assign stock_sel   = slot_ok ? stock[slot_idx] : '0;
  assign qty_wide    = {16'b0, in_qty};
  assign qty_m       = qty_wide[STOCK_BITS-1:0];

  // price of the chosen slot and coin arithmetic
  logic [vmc_pkg::PRICE_W-1:0] price;
  logic [vmc_pkg::BAL_W-1:0]   price_ext;
  logic [vmc_pkg::BAL_W-1:0]   bal_sum;

  assign price     = price_table[chosen_slot * vmc_pkg::PRICE_W +: vmc_pkg::PRICE_W];
  assign price_ext = {1'b0, price};
  assign bal_sum   = balance + {4'b0, vmc_pkg::coin_value(in_coin)};

  // stock write port
  logic                  stk_we;
  logic [IDX_W-1:0]      stk_idx;
  logic [STOCK_BITS-1:0] stk_data;

  // result of the event in the work stage
  logic [vmc_pkg::STATUS_W-1:0] r_status;
  logic                         r_disp;
  logic [vmc_pkg::BAL_W-1:0]    r_ret;
  logic                         r_coin_back;
  logic                         show_set;
  logic [vmc_pkg::SLOT_W-1:0]   show_slot;

  always_comb begin
    state_next        = state;
    balance_next      = balance;
    chosen_next       = chosen_slot;
    chosen_stock_next = chosen_stock;
    stk_we            = 1'b0;
    stk_idx           = chosen_idx;
    stk_data          = chosen_stock - 1'b1;
    r_status          = vmc_pkg::STS_NONE_SELECTED;
    r_disp            = 1'b0;
    r_ret             = '0;
    r_coin_back       = 1'b0;
    show_set          = 1'b0;
    show_slot         = chosen_slot;

    case (in_mode)
      vmc_pkg::MODE_SELECT: begin
        if (state == vmc_pkg::ST_SELECTED || state == vmc_pkg::ST_PAID) begin
          r_status = vmc_pkg::STS_ALREADY_SEL;
        end else if (slot_ok && stock_sel != '0) begin
          chosen_next       = in_slot;
          chosen_stock_next = stock_sel;
          state_next        = vmc_pkg::ST_SELECTED;
          r_status          = vmc_pkg::STS_SELECTED;
        end else begin
          r_status = vmc_pkg::STS_UNAVAILABLE;
        end
      end
      vmc_pkg::MODE_COIN: begin
        case (state)
          vmc_pkg::ST_SELECTED: begin
            balance_next = bal_sum;
            if (bal_sum >= price_ext) begin
              state_next = vmc_pkg::ST_PAID;
              r_status   = vmc_pkg::STS_PAID;
            end else begin
              r_status = vmc_pkg::STS_COIN_TAKEN;
            end
          end
          vmc_pkg::ST_PAID: begin
            r_status    = vmc_pkg::STS_COIN_REJECTED;
            r_coin_back = 1'b1;
          end
          default: begin
            r_status    = vmc_pkg::STS_SELECT_FIRST;
            r_coin_back = 1'b1;
          end
        endcase
      end
      vmc_pkg::MODE_DISPENSE: begin
        case (state)
          vmc_pkg::ST_SELECTED: begin
            r_status = vmc_pkg::STS_INSUFFICIENT;
          end
          vmc_pkg::ST_PAID: begin
            show_set  = 1'b1;
            show_slot = chosen_slot;
            if (chosen_stock == '0) begin
              // stock emptied after selection: refund all
              r_status = vmc_pkg::STS_UNAVAILABLE;
              r_ret    = balance;
            end else if (balance < price_ext) begin
              // price raised after payment: refund all
              r_status = vmc_pkg::STS_INSUFFICIENT;
              r_ret    = balance;
            end else begin
              stk_we   = 1'b1;
              r_ret    = balance - price_ext;
              r_disp   = 1'b1;
              r_status = vmc_pkg::STS_DISPENSED;
            end
            state_next   = vmc_pkg::ST_IDLE;
            balance_next = '0;
            chosen_next  = '0;
          end
          default: begin
            r_status = vmc_pkg::STS_NONE_SELECTED;
          end
        endcase
      end
      vmc_pkg::MODE_REFUND: begin
        if (state == vmc_pkg::ST_SELECTED || state == vmc_pkg::ST_PAID) begin
          r_ret        = balance;
          r_status     = vmc_pkg::STS_REFUNDED;
          state_next   = vmc_pkg::ST_IDLE;
          balance_next = '0;
          chosen_next  = '0;
        end else begin
          r_status = vmc_pkg::STS_NOTHING_REFUND;
        end
      end
      vmc_pkg::MODE_LOAD: begin
        if (slot_ok) begin
          stk_we   = 1'b1;
          stk_idx  = slot_idx;
          stk_data = qty_m;
          // keep the chosen slot's copy in step with the store
          if (in_slot == chosen_slot) begin
            chosen_stock_next = qty_m;
          end
        end
        r_status = vmc_pkg::STS_STOCK_LOADED;
      end
      default: begin
        r_status = vmc_pkg::STS_NONE_SELECTED;
      end
    endcase

    // selected or dispensed slot, else the chosen slot after the event
    if (!show_set) begin
      show_slot = chosen_next;
    end
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      price_table  <= '0;
      in_valid     <= 1'b0;
      out_valid    <= 1'b0;
      state        <= vmc_pkg::ST_IDLE;
      balance      <= '0;
      chosen_slot  <= '0;
      chosen_stock <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        stock[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        price_table <= cfg_wr_data;
      end
      if (evt_fire) begin
        in_valid <= 1'b1;
      end else if (work_fire) begin
        in_valid <= 1'b0;
      end
      if (work_fire) begin
        out_valid    <= 1'b1;
        state        <= state_next;
        balance      <= balance_next;
        chosen_slot  <= chosen_next;
        chosen_stock <= chosen_stock_next;
        if (stk_we) begin
          stock[stk_idx] <= stk_data;
        end
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (evt_fire) begin
      in_mode <= evt.mode;
      in_slot <= evt.slot;
      in_coin <= evt.coin_kind;
      in_qty  <= evt.quantity;
    end
    if (work_fire) begin
      out_status    <= r_status;
      out_disp      <= r_disp;
      out_slot      <= show_slot;
      out_ret       <= r_ret;
      out_coin_back <= r_coin_back;
      out_bal       <= balance_next;
    end
  end

  assign res.valid           = out_valid;
  assign res.status          = out_status;
  assign res.dispensed       = out_disp;
  assign res.dispensed_slot  = out_slot;
  assign res.returned_amount = out_ret;
  assign res.coin_returned   = out_coin_back;
  assign res.balance_now     = out_bal;

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the vending machine controller. A driver and a
// monitor run as clocked processes on the two valid/ready channels. The driver
// takes event items from a queue and, on each accept, runs a cycle-free model
// of the controller that pushes the result it must produce. The monitor pops
// and compares every field. Stimulus is a short directed run of the corner
// cases, then random purchase sequences under several price tables.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD   = 120;

  // codes the package leaves out
  localparam logic [vmc_pkg::COIN_W-1:0] COIN_QUARTER  = 2'd3;
  localparam logic [vmc_pkg::MODE_W-1:0] MODE_SPARE_LO = 3'd5;

  typedef struct packed {
    logic [vmc_pkg::MODE_W-1:0] mode;
    logic [vmc_pkg::SLOT_W-1:0] slot;
    logic [vmc_pkg::COIN_W-1:0] coin_kind;
    logic [vmc_pkg::QTY_W-1:0]  quantity;
  } vend_event_t;

  typedef struct packed {
    logic [vmc_pkg::STATUS_W-1:0] status;
    logic                         dispensed;
    logic [vmc_pkg::SLOT_W-1:0]   dispensed_slot;
    logic [vmc_pkg::BAL_W-1:0]    returned_amount;
    logic                         coin_returned;
    logic [vmc_pkg::BAL_W-1:0]    balance_now;
  } vend_result_t;

  logic                        clk;
  logic                        rst;
  logic                        cfg_wr_en;
  logic [vmc_pkg::TABLE_W-1:0] cfg_wr_data;

  vmc_event_if  evt();
  vmc_result_if res();

  vending_machine_controller DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .evt         (evt),
    .res         (res)
  );

  // shadow copy of the controller state
  vmc_pkg::state_t             mdl_state;
  logic [vmc_pkg::BAL_W-1:0]   mdl_balance;
  logic [vmc_pkg::SLOT_W-1:0]  mdl_chosen;
  logic [vmc_pkg::QTY_W-1:0]   mdl_stock [8];
  logic [vmc_pkg::TABLE_W-1:0] mdl_prices;

  vend_event_t  pending_events [$];
  vend_result_t expected_results [$];
  vend_event_t  cur_event;

  bit calm;            // no random idling on either side
  int hold_requests;   // long receiver hold-offs asked for
  int holds_served;
  int send_gap;
  int recv_stall;
  int hold_left;
  int fail_count;
  int cycle_count;

  // 2 ns clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // coin worth in cents
  function automatic logic [vmc_pkg::BAL_W-1:0] coin_cents(
      input logic [vmc_pkg::COIN_W-1:0] kind);
    logic [vmc_pkg::BAL_W-1:0] v;
    case (kind)
      vmc_pkg::COIN_PENNY:  v = vmc_pkg::BAL_W'(vmc_pkg::PENNY);
      vmc_pkg::COIN_NICKEL: v = vmc_pkg::BAL_W'(vmc_pkg::NICKEL);
      vmc_pkg::COIN_DIME:   v = vmc_pkg::BAL_W'(vmc_pkg::DIME);
      default:              v = vmc_pkg::BAL_W'(vmc_pkg::QUARTER);
    endcase
    return v;
  endfunction

  function automatic void back_to_idle();
    mdl_state   = vmc_pkg::ST_IDLE;
    mdl_balance = '0;
    mdl_chosen  = '0;
  endfunction

  // advance the shadow machine by one event, return the result it causes
  function automatic vend_result_t vend_predict(input vend_event_t ev);
    vend_result_t    r;
    vmc_pkg::state_t st;
    logic [7:0]      cost;
    logic            show_chosen;
    r = '0;
    r.status = vmc_pkg::STS_NONE_SELECTED;
    show_chosen = 1'b1;
    // unreachable state code counts as idle
    st = (mdl_state == vmc_pkg::ST_SELECTED || mdl_state == vmc_pkg::ST_PAID) ?
         mdl_state : vmc_pkg::ST_IDLE;
    case (ev.mode)
      vmc_pkg::MODE_SELECT: begin
        if (st != vmc_pkg::ST_IDLE) begin
          r.status = vmc_pkg::STS_ALREADY_SEL;
        end else if (mdl_stock[ev.slot] != '0) begin
          mdl_chosen = ev.slot;
          mdl_state  = vmc_pkg::ST_SELECTED;
          r.status   = vmc_pkg::STS_SELECTED;
        end else begin
          r.status = vmc_pkg::STS_UNAVAILABLE;
        end
      end
      vmc_pkg::MODE_COIN: begin
        if (st == vmc_pkg::ST_IDLE) begin
          r.status = vmc_pkg::STS_SELECT_FIRST;
          r.coin_returned = 1'b1;
        end else if (st == vmc_pkg::ST_PAID) begin
          r.status = vmc_pkg::STS_COIN_REJECTED;
          r.coin_returned = 1'b1;
        end else begin
          mdl_balance = mdl_balance + coin_cents(ev.coin_kind);
          cost = mdl_prices[mdl_chosen*8 +: 8];
          if (mdl_balance >= {1'b0, cost}) begin
            mdl_state = vmc_pkg::ST_PAID;
            r.status  = vmc_pkg::STS_PAID;
          end else begin
            r.status = vmc_pkg::STS_COIN_TAKEN;
          end
        end
      end
      vmc_pkg::MODE_DISPENSE: begin
        if (st == vmc_pkg::ST_IDLE) begin
          r.status = vmc_pkg::STS_NONE_SELECTED;
        end else if (st == vmc_pkg::ST_SELECTED) begin
          r.status = vmc_pkg::STS_INSUFFICIENT;
        end else begin
          cost = mdl_prices[mdl_chosen*8 +: 8];
          r.dispensed_slot = mdl_chosen;
          show_chosen = 1'b0;
          if (mdl_stock[mdl_chosen] == '0) begin
            // stock emptied after selection: full refund
            r.status = vmc_pkg::STS_UNAVAILABLE;
            r.returned_amount = mdl_balance;
          end else if (mdl_balance < {1'b0, cost}) begin
            // price raised after payment: full refund
            r.status = vmc_pkg::STS_INSUFFICIENT;
            r.returned_amount = mdl_balance;
          end else begin
            mdl_stock[mdl_chosen] = mdl_stock[mdl_chosen] - 1'b1;
            r.returned_amount = mdl_balance - {1'b0, cost};
            r.dispensed = 1'b1;
            r.status = vmc_pkg::STS_DISPENSED;
          end
          back_to_idle();
        end
      end
      vmc_pkg::MODE_REFUND: begin
        if (st == vmc_pkg::ST_IDLE) begin
          r.status = vmc_pkg::STS_NOTHING_REFUND;
        end else begin
          r.returned_amount = mdl_balance;
          r.status = vmc_pkg::STS_REFUNDED;
          back_to_idle();
        end
      end
      vmc_pkg::MODE_LOAD: begin
        mdl_stock[ev.slot] = ev.quantity;
        r.status = vmc_pkg::STS_STOCK_LOADED;
      end
      default: r.status = vmc_pkg::STS_NONE_SELECTED;
    endcase
    if (show_chosen) r.dispensed_slot = mdl_chosen;
    r.balance_now = mdl_balance;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // driver: one item per handshake, random gap after each accept
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    logic offer;
    if (rst) begin
      evt.valid <= 1'b0;
      send_gap = 0;
    end else begin
      offer = evt.valid;
      if (evt.valid && evt.ready) begin
        // predict at accept, in order of arrival at the block
        expected_results.push_back(vend_predict(cur_event));
        offer = 1'b0;
        send_gap = calm ? 0 : $urandom_range(0, 9);
      end
      if (!offer) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_events.size() != 0) begin
          cur_event = pending_events.pop_front();
          evt.mode      <= cur_event.mode;
          evt.slot      <= cur_event.slot;
          evt.coin_kind <= cur_event.coin_kind;
          evt.quantity  <= cur_event.quantity;
          offer = 1'b1;
        end
      end
      // single assignment per edge so valid never glitches low between items
      evt.valid <= offer;
    end
  end

  // --------------------------------------------------------------------------
  // monitor: random stall after each result, plus long hold-offs on request
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    vend_result_t want;
    if (rst) begin
      res.ready <= 1'b0;
      recv_stall = 0;
      hold_left = 0;
    end else begin
      if (res.valid && res.ready) begin
        if (expected_results.size() == 0) begin
          $error("result item with nothing expected, status %0d", res.status);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", want.status, res.status);
          check_field("dispensed", want.dispensed, res.dispensed);
          check_field("dispensed_slot", want.dispensed_slot, res.dispensed_slot);
          check_field("returned_amount", want.returned_amount, res.returned_amount);
          check_field("coin_returned", want.coin_returned, res.coin_returned);
          check_field("balance_now", want.balance_now, res.balance_now);
        end
        recv_stall = calm ? 0 : $urandom_range(0, 9);
      end
      // long hold-off lets the block fill up and push back on its input
      if (holds_served < hold_requests) begin
        holds_served++;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        res.ready <= 1'b0;
      end else if (recv_stall > 0) begin
        recv_stall--;
        res.ready <= 1'b0;
      end else begin
        res.ready <= 1'b1;
      end
    end
  end

  // run-away guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  function automatic void queue_event(input logic [vmc_pkg::MODE_W-1:0] m,
                                      input logic [vmc_pkg::SLOT_W-1:0] s,
                                      input logic [vmc_pkg::COIN_W-1:0] k,
                                      input logic [vmc_pkg::QTY_W-1:0]  q);
    vend_event_t ev;
    ev.mode      = m;
    ev.slot      = s;
    ev.coin_kind = k;
    ev.quantity  = q;
    pending_events.push_back(ev);
  endfunction

  // random event, any mode including the unused codes
  function automatic int queue_noise();
    queue_event(vmc_pkg::MODE_W'($urandom), vmc_pkg::SLOT_W'($urandom),
                vmc_pkg::COIN_W'($urandom), vmc_pkg::QTY_W'($urandom));
    return 1;
  endfunction

  // well-formed purchase with random content and a random ending
  function automatic int queue_purchase();
    logic [vmc_pkg::SLOT_W-1:0] s;
    logic [vmc_pkg::COIN_W-1:0] k;
    int cost, paid_in, coins, max_coins, pushed, ending;
    bit early;
    s = vmc_pkg::SLOT_W'($urandom);
    pushed = 0;
    if ($urandom_range(0, 2) == 0) begin
      // restock, now and then with zero to empty the slot
      queue_event(vmc_pkg::MODE_LOAD, s, vmc_pkg::COIN_W'($urandom),
                  ($urandom_range(0, 9) == 0) ? vmc_pkg::QTY_W'(0) :
                                                vmc_pkg::QTY_W'($urandom_range(1, 255)));
      pushed++;
    end
    queue_event(vmc_pkg::MODE_SELECT, s, vmc_pkg::COIN_W'($urandom),
                vmc_pkg::QTY_W'($urandom));
    pushed++;
    cost = int'(mdl_prices[s*8 +: 8]);
    early = ($urandom_range(0, 7) == 0);
    max_coins = early ? $urandom_range(1, 3) : 40;
    paid_in = 0;
    coins = 0;
    while (coins == 0 || (paid_in < cost && coins < max_coins)) begin
      k = vmc_pkg::COIN_W'($urandom);
      paid_in += int'(coin_cents(k));
      queue_event(vmc_pkg::MODE_COIN, vmc_pkg::SLOT_W'($urandom), k,
                  vmc_pkg::QTY_W'($urandom));
      coins++;
      pushed++;
    end
    if (early) begin
      queue_event(vmc_pkg::MODE_REFUND, vmc_pkg::SLOT_W'($urandom),
                  vmc_pkg::COIN_W'($urandom), vmc_pkg::QTY_W'($urandom));
      return pushed + 1;
    end
    ending = $urandom_range(0, 19);
    if (ending < 16) begin
      if (ending >= 13) begin
        // extra coin once paid
        queue_event(vmc_pkg::MODE_COIN, vmc_pkg::SLOT_W'($urandom),
                    vmc_pkg::COIN_W'($urandom), vmc_pkg::QTY_W'($urandom));
        pushed++;
      end
      queue_event(vmc_pkg::MODE_DISPENSE, vmc_pkg::SLOT_W'($urandom),
                  vmc_pkg::COIN_W'($urandom), vmc_pkg::QTY_W'($urandom));
      pushed++;
    end else if (ending < 19) begin
      queue_event(vmc_pkg::MODE_REFUND, vmc_pkg::SLOT_W'($urandom),
                  vmc_pkg::COIN_W'($urandom), vmc_pkg::QTY_W'($urandom));
      pushed++;
    end
    // otherwise leave the machine holding a selection
    return pushed;
  endfunction

  // wait until nothing is queued, offered or owed
  task automatic wait_drained();
    @(negedge clk);
    while (pending_events.size() != 0 || evt.valid || expected_results.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_prices(input logic [vmc_pkg::TABLE_W-1:0] table_val);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= table_val;
    mdl_prices = table_val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [vmc_pkg::TABLE_W-1:0] cheap_prices();
    logic [vmc_pkg::TABLE_W-1:0] t;
    for (int i = 0; i < vmc_pkg::PRICE_SLOTS; i++) t[i*8 +: 8] = 8'($urandom_range(0, 40));
    return t;
  endfunction

  task automatic run_phase(input int n, input bit quiet, input bit squeeze);
    int done;
    done = 0;
    calm = quiet;
    while (done < n)
      done += ($urandom_range(0, 3) != 0) ? queue_purchase() : queue_noise();
    if (squeeze) hold_requests++;
    wait_drained();
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst           = 1'b1;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    evt.valid     = 1'b0;
    evt.mode      = '0;
    evt.slot      = '0;
    evt.coin_kind = '0;
    evt.quantity  = '0;
    res.ready     = 1'b0;
    calm          = 1'b0;
    hold_requests = 0;
    holds_served  = 0;
    fail_count    = 0;
    cycle_count   = 0;
    mdl_prices    = '0;
    for (int i = 0; i < 8; i++) mdl_stock[i] = '0;
    back_to_idle();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // slot 0 costs 40, slot 1 is free, slot 7 costs 25
    write_prices(64'h1950_4030_2010_0028);

    // events with nothing selected
    queue_event(vmc_pkg::MODE_COIN, 3'd0, COIN_QUARTER, 8'd0);
    queue_event(vmc_pkg::MODE_DISPENSE, 3'd0, vmc_pkg::COIN_PENNY, 8'd0);
    queue_event(vmc_pkg::MODE_REFUND, 3'd0, vmc_pkg::COIN_PENNY, 8'd0);
    queue_event(vmc_pkg::MODE_SELECT, 3'd2, vmc_pkg::COIN_PENNY, 8'd0);    // empty slot
    queue_event(MODE_SPARE_LO, 3'd7, COIN_QUARTER, 8'hff);                 // unused mode
    queue_event(vmc_pkg::MODE_LOAD, 3'd7, vmc_pkg::COIN_PENNY, 8'd255);
    queue_event(vmc_pkg::MODE_LOAD, 3'd0, vmc_pkg::COIN_PENNY, 8'd1);
    // full purchase with every coin kind and change back
    queue_event(vmc_pkg::MODE_SELECT, 3'd0, vmc_pkg::COIN_PENNY, 8'd0);
    queue_event(vmc_pkg::MODE_SELECT, 3'd7, vmc_pkg::COIN_PENNY, 8'd0);    // already selected
    queue_event(vmc_pkg::MODE_DISPENSE, 3'd0, vmc_pkg::COIN_PENNY, 8'd0);  // not paid yet
    queue_event(vmc_pkg::MODE_COIN, 3'd0, vmc_pkg::COIN_PENNY, 8'd0);
    queue_event(vmc_pkg::MODE_COIN, 3'd0, vmc_pkg::COIN_NICKEL, 8'd0);
    queue_event(vmc_pkg::MODE_COIN, 3'd0, vmc_pkg::COIN_DIME, 8'd0);
    queue_event(vmc_pkg::MODE_COIN, 3'd0, COIN_QUARTER, 8'd0);
    queue_event(vmc_pkg::MODE_COIN, 3'd0, vmc_pkg::COIN_DIME, 8'd0);       // rejected when paid
    queue_event(vmc_pkg::MODE_DISPENSE, 3'd0, vmc_pkg::COIN_PENNY, 8'd0);
    // stock emptied between payment and dispense
    queue_event(vmc_pkg::MODE_LOAD, 3'd1, vmc_pkg::COIN_PENNY, 8'd2);
    queue_event(vmc_pkg::MODE_SELECT, 3'd1, vmc_pkg::COIN_PENNY, 8'd0);
    queue_event(vmc_pkg::MODE_COIN, 3'd1, vmc_pkg::COIN_PENNY, 8'd0);
    queue_event(vmc_pkg::MODE_LOAD, 3'd1, vmc_pkg::COIN_PENNY, 8'd0);
    queue_event(vmc_pkg::MODE_DISPENSE, 3'd1, vmc_pkg::COIN_PENNY, 8'd0);
    // pay for slot 7, then raise its price before dispensing
    queue_event(vmc_pkg::MODE_SELECT, 3'd7, vmc_pkg::COIN_PENNY, 8'd0);
    queue_event(vmc_pkg::MODE_COIN, 3'd7, COIN_QUARTER, 8'd0);
    write_prices(64'hff50_4030_2010_0028);
    queue_event(vmc_pkg::MODE_DISPENSE, 3'd7, vmc_pkg::COIN_PENNY, 8'd0);
    // refund with money held
    queue_event(vmc_pkg::MODE_SELECT, 3'd7, vmc_pkg::COIN_PENNY, 8'd0);
    queue_event(vmc_pkg::MODE_COIN, 3'd7, vmc_pkg::COIN_DIME, 8'd0);
    queue_event(vmc_pkg::MODE_REFUND, 3'd7, vmc_pkg::COIN_PENNY, 8'd0);

    // random phases over several price tables
    write_prices(cheap_prices());
    run_phase(125, 1'b0, 1'b0);
    run_phase(125, 1'b0, 1'b0);       // random gaps on both sides
    write_prices('0);
    run_phase(200, 1'b1, 1'b0);       // back-to-back, no idling
    write_prices('1);
    run_phase(200, 1'b0, 1'b1);       // long receiver hold-off
    write_prices({$urandom, $urandom});
    run_phase(250, 1'b0, 1'b0);
    write_prices(cheap_prices());
    run_phase(250, 1'b0, 1'b1);

    wait_drained();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
